### hw/rtl/ptss_pkg.sv
package ptss_pkg;

  localparam int MAX_SPAN     = 1024;
  localparam int SEG_PIXELS   = 16;
  localparam int SEG_LOG2     = $clog2(SEG_PIXELS);
  localparam int SWIM_ENTRIES = 256;
  localparam int SWIM_AW      = $clog2(SWIM_ENTRIES);
  localparam int SWIM_W       = 22;
  localparam int FRAC_BITS    = 18;
  localparam int MAX_TEX_LOG2 = 10;

  localparam int CNT_W   = $clog2(MAX_SPAN + 1);
  localparam int SEGS_W  = $clog2(MAX_SPAN / SEG_PIXELS + 1);
  localparam int POS_W   = $clog2(MAX_SPAN);
  localparam int NPIX_W  = $clog2(SEG_PIXELS + 1);
  localparam int TEX_W   = 2 * MAX_TEX_LOG2;
  localparam int LOG2_W  = 4;
  localparam int COORD_W = 32;
  localparam int ACC_W   = COORD_W + 1;
  localparam int DEPTH_W = 31;

  // divider: signed dividend, unsigned divisor, truncating quotient
  localparam int DIVD_W  = ACC_W + FRAC_BITS + 1;
  localparam int MAG_W   = DIVD_W - 1;
  localparam int DIVS_W  = DEPTH_W;
  localparam int DCNT_W  = $clog2(MAG_W + 1);

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_STEP = 2'd1,
    CMD_SWIM = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_WALL  = 2'd0,
    MODE_SWIRL = 2'd1,
    MODE_SKY   = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } reg_e;

  typedef struct packed {
    logic                     start;
    logic signed [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [DIVD_W-1:0] quotient;
  } div_rsp_t;

  // clamp a quotient to the signed 32-bit range
  function automatic logic [COORD_W-1:0] sat32(input logic signed [DIVD_W-1:0] q);
    logic [DIVD_W-COORD_W:0] top;
    logic [COORD_W-1:0]      res;
    top = q[DIVD_W-1:COORD_W-1];
    if ((top == '0) || (top == '1)) begin
      res = q[COORD_W-1:0];
    end else if (q[DIVD_W-1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### hw/rtl/ptss_ram.sv
module ptss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/ptss_div.sv
module ptss_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptss_pkg::div_req_t req_i,
  output ptss_pkg::div_rsp_t rsp_o
);

  localparam int MW = ptss_pkg::MAG_W;
  localparam int SW = ptss_pkg::DIVS_W;

  logic                         busy_q, done_q, neg_q;
  logic [ptss_pkg::DCNT_W-1:0]  cnt_q;
  logic [SW-1:0]                rem_q, dvs_q;
  logic [MW-1:0]                quo_q;
  logic [ptss_pkg::DIVD_W-1:0]  abs_in;
  logic [SW:0]                  trial, trial_sub;
  logic                         ge;

  assign abs_in    = req_i.dividend[ptss_pkg::DIVD_W-1] ? -req_i.dividend : req_i.dividend;
  assign trial     = {rem_q, quo_q[MW-1]};
  assign ge        = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q && req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ptss_pkg::DCNT_W'(MW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ptss_pkg::DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && req_i.start) begin
      neg_q <= req_i.dividend[ptss_pkg::DIVD_W-1];
      quo_q <= abs_in[MW-1:0];
      rem_q <= '0;
      // a zero divisor divides by one
      dvs_q <= (req_i.divisor == '0) ? SW'(1) : req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? trial_sub[SW-1:0] : trial[SW-1:0];
      quo_q <= {quo_q[MW-2:0], ge};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

### hw/rtl/ptss_texaddr.sv
module ptss_texaddr (
  input  logic [ptss_pkg::COORD_W-1:0] u_i,
  input  logic [ptss_pkg::COORD_W-1:0] v_i,
  input  logic [ptss_pkg::LOG2_W-1:0]  wlog_i,
  input  logic [ptss_pkg::LOG2_W-1:0]  hlog_i,
  input  ptss_pkg::mode_e              mode_i,
  output logic [ptss_pkg::TEX_W-1:0]   addr_o,
  output logic                         oor_o
);

  localparam int ML = ptss_pkg::MAX_TEX_LOG2;
  localparam int IW = ptss_pkg::COORD_W - ptss_pkg::FRAC_BITS;

  logic [ptss_pkg::LOG2_W-1:0] wl, hl;
  logic [ML:0]                 wfull, hfull;
  logic [ML-1:0]               wmask, hmask;
  logic [IW-1:0]               ui, vi;
  logic                        u_bad, v_bad;

  always_comb begin
    wl    = (wlog_i > ptss_pkg::LOG2_W'(ML)) ? ptss_pkg::LOG2_W'(ML) : wlog_i;
    hl    = (hlog_i > ptss_pkg::LOG2_W'(ML)) ? ptss_pkg::LOG2_W'(ML) : hlog_i;
    wfull = ((ML+1)'(1) << wl) - (ML+1)'(1);
    hfull = ((ML+1)'(1) << hl) - (ML+1)'(1);
    wmask = (mode_i == ptss_pkg::MODE_SKY) ? wfull[ML:1] : wfull[ML-1:0];
    hmask = hfull[ML-1:0];
    ui    = u_i[ptss_pkg::COORD_W-1:ptss_pkg::FRAC_BITS];
    vi    = v_i[ptss_pkg::COORD_W-1:ptss_pkg::FRAC_BITS];
    u_bad = ui[IW-1] || (ui[IW-2:0] > (IW-1)'(wmask));
    v_bad = vi[IW-1] || (vi[IW-2:0] > (IW-1)'(hmask));
    oor_o = (mode_i == ptss_pkg::MODE_WALL) && (u_bad || v_bad);
    addr_o = ({{ML{1'b0}}, vi[ML-1:0] & hmask} << wl)
           + {{ML{1'b0}}, ui[ML-1:0] & wmask};
  end

endmodule

### hw/rtl/perspective_texture_span_stepper.sv
// Channel   Handshake                Carries
// input     in_valid_i / in_stall_o  command, span endpoints, count, mode, mip, swim entry
// output    out_valid_o / out_stall_i texel address, pixel index, flags
// config    cfg_valid_i / cfg_ready_o register index and data, always ready
//
// One item at a time. Every divide runs on one shared restoring divider, one quotient
// bit a cycle. A load takes five divides; a full step two divides, the swirl states
// in swirl mode and 16 pixels; a tail step up to four divides plus its pixels.
// Reset clears the control state and the swim table's valid bits (all read as zero).
// Output stalls hold the pixel stepper; the input is stalled until the item is done.
module perspective_texture_span_stepper (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [30:0] left_inv_depth_i,
  input  logic [30:0] right_inv_depth_i,
  input  logic [31:0] left_u_over_z_i,
  input  logic [31:0] right_u_over_z_i,
  input  logic [31:0] left_v_over_z_i,
  input  logic [31:0] right_v_over_z_i,
  input  logic [10:0] pixel_count_i,
  input  logic [1:0]  draw_mode_i,
  input  logic [1:0]  mip_level_i,
  input  logic [7:0]  swim_index_i,
  input  logic [21:0] swim_value_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [19:0] texel_address_o,
  output logic [9:0]  pixel_index_o,
  output logic        out_of_range_o,
  output logic        segment_last_o,
  output logic        span_last_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_data_i
);

  localparam int CW = ptss_pkg::COORD_W;
  localparam int AW = ptss_pkg::ACC_W;
  localparam int DW = ptss_pkg::DIVD_W;
  localparam int FB = ptss_pkg::FRAC_BITS;
  localparam int NW = ptss_pkg::NPIX_W;
  localparam int SWW = ptss_pkg::SWIM_W;
  localparam int SHW = $clog2(CW);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SW_RDV,
    ST_SW_ADDU,
    ST_SW_RDU,
    ST_SW_ADDV,
    ST_POST,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    OP_INC_Z,
    OP_INC_U,
    OP_INC_V,
    OP_CRD_U,
    OP_CRD_V,
    OP_TAIL_U,
    OP_TAIL_V
  } op_e;

  state_e                        state_q;
  op_e                           op_q;
  logic                          loading_q, full_q, final_q, active_q;
  logic [ptss_pkg::SEGS_W-1:0]   segs_q;
  logic [ptss_pkg::SEG_LOG2-1:0] tail_q;
  logic [ptss_pkg::POS_W-1:0]    pos_q;
  ptss_pkg::mode_e               mode_q;
  logic [1:0]                    mip_q;
  logic [ptss_pkg::CNT_W-1:0]    cnt_q;
  logic [ptss_pkg::LOG2_W-1:0]   wlog_q, hlog_q;

  // span datapath
  logic signed [AW-1:0]          acc_z_q, acc_u_q, acc_v_q;
  logic signed [AW-1:0]          inc_z_q, inc_u_q, inc_v_q;
  logic [ptss_pkg::DEPTH_W-1:0]  end_z_q;
  logic [CW-1:0]                 end_u_q, end_v_q;
  logic [CW-1:0]                 cur_u_q, cur_v_q, nu_q, nv_q, du_q, dv_q;
  logic [NW-1:0]                 n_q, k_q;

  // swim table valid bits
  logic [ptss_pkg::SWIM_ENTRIES-1:0] swim_vld_q;
  logic                              vld_rd_q;

  // output register
  logic                          out_valid_q, seg_last_q, span_last_q, oor_q;
  logic [ptss_pkg::TEX_W-1:0]    addr_q;
  logic [ptss_pkg::POS_W-1:0]    pix_q;

  ptss_pkg::div_req_t            div_req;
  ptss_pkg::div_rsp_t            div_rsp;

  logic                          accept, fire, last_pix;
  logic [ptss_pkg::CNT_W-1:0]    cnt_sat;
  logic                          use_acc;
  logic signed [AW:0]            diff_inc;
  logic signed [AW-1:0]          crd_src, diff_tail;
  logic signed [AW-1:0]          step_u, step_v, step_u_sh, step_v_sh;
  logic [NW-1:0]                 n_m1;
  logic [CW-1:0]                 sw_shv;
  logic [SHW-1:0]                sw_sh;
  logic [ptss_pkg::SWIM_AW-1:0]  sw_idx;
  logic [SWW-1:0]                ram_rdata, sw_val;
  logic signed [CW-1:0]          sw_off;
  logic [ptss_pkg::TEX_W-1:0]    pix_addr;
  logic                          pix_oor;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign fire        = !out_valid_q || !out_stall_i;
  assign last_pix    = (k_q == n_q - NW'(1));
  assign cnt_sat     = (pixel_count_i > ptss_pkg::CNT_W'(ptss_pkg::MAX_SPAN))
                       ? ptss_pkg::CNT_W'(ptss_pkg::MAX_SPAN) : pixel_count_i;
  assign use_acc     = loading_q || full_q;
  assign n_m1        = n_q - NW'(1);

  // divider operand selection
  always_comb begin
    diff_inc  = '0;
    crd_src   = use_acc ? acc_u_q : $signed({end_u_q[CW-1], end_u_q});
    diff_tail = $signed({nu_q[CW-1], nu_q}) - $signed({cur_u_q[CW-1], cur_u_q});
    div_req.start    = (state_q == ST_DIV_GO);
    div_req.dividend = '0;
    div_req.divisor  = {{(ptss_pkg::DIVS_W-ptss_pkg::CNT_W){1'b0}}, cnt_q};
    case (op_q)
      OP_INC_Z: diff_inc = $signed({3'b000, end_z_q}) - $signed({acc_z_q[AW-1], acc_z_q});
      OP_INC_U: diff_inc = $signed({end_u_q[CW-1], end_u_q[CW-1], end_u_q})
                           - $signed({acc_u_q[AW-1], acc_u_q});
      OP_INC_V: diff_inc = $signed({end_v_q[CW-1], end_v_q[CW-1], end_v_q})
                           - $signed({acc_v_q[AW-1], acc_v_q});
      OP_CRD_V: crd_src  = use_acc ? acc_v_q : $signed({end_v_q[CW-1], end_v_q});
      OP_TAIL_V: diff_tail = $signed({nv_q[CW-1], nv_q}) - $signed({cur_v_q[CW-1], cur_v_q});
      default: ;
    endcase
    case (op_q)
      OP_INC_Z, OP_INC_U, OP_INC_V: begin
        // (right - left) * 16 / count
        div_req.dividend = {{(DW-AW-1-ptss_pkg::SEG_LOG2){diff_inc[AW]}}, diff_inc,
                            {ptss_pkg::SEG_LOG2{1'b0}}};
      end
      OP_CRD_U, OP_CRD_V: begin
        div_req.dividend = {{(DW-AW-FB){crd_src[AW-1]}}, crd_src, {FB{1'b0}}};
        div_req.divisor  = use_acc ? acc_z_q[ptss_pkg::DEPTH_W-1:0] : end_z_q;
      end
      OP_TAIL_U, OP_TAIL_V: begin
        div_req.dividend = {{(DW-AW){diff_tail[AW-1]}}, diff_tail};
        div_req.divisor  = {{(ptss_pkg::DIVS_W-NW){1'b0}}, n_m1};
      end
      default: ;
    endcase
  end

  ptss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // swirl lookup: index from the other coordinate, shifted by mip
  always_comb begin
    sw_sh  = SHW'(FB - 1) - {{(SHW-2){1'b0}}, mip_q};
    sw_shv = (state_q == ST_SW_RDU) ? (nu_q >> sw_sh) : (nv_q >> sw_sh);
    sw_idx = sw_shv[ptss_pkg::SWIM_AW-1:0];
    sw_val = vld_rd_q ? ram_rdata : '0;
    sw_off = $signed({{(CW-SWW){sw_val[SWW-1]}}, sw_val}) >>> mip_q;
  end

  ptss_ram #(
    .WIDTH (SWW),
    .DEPTH (ptss_pkg::SWIM_ENTRIES)
  ) u_swim (
    .clk_i   (clk_i),
    .we_i    (accept && (command_i == ptss_pkg::CMD_SWIM)),
    .waddr_i (swim_index_i),
    .wdata_i (swim_value_i),
    .raddr_i (sw_idx),
    .rdata_o (ram_rdata)
  );

  // full-segment slope: floor((next - cur) / 16)
  always_comb begin
    step_u    = $signed({nu_q[CW-1], nu_q}) - $signed({cur_u_q[CW-1], cur_u_q});
    step_v    = $signed({nv_q[CW-1], nv_q}) - $signed({cur_v_q[CW-1], cur_v_q});
    step_u_sh = step_u >>> ptss_pkg::SEG_LOG2;
    step_v_sh = step_v >>> ptss_pkg::SEG_LOG2;
  end

  ptss_texaddr u_addr (
    .u_i    (cur_u_q),
    .v_i    (cur_v_q),
    .wlog_i (wlog_q),
    .hlog_i (hlog_q),
    .mode_i (mode_q),
    .addr_o (pix_addr),
    .oor_o  (pix_oor)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_INC_Z;
      loading_q   <= 1'b0;
      full_q      <= 1'b0;
      final_q     <= 1'b0;
      active_q    <= 1'b0;
      segs_q      <= '0;
      tail_q      <= '0;
      pos_q       <= '0;
      mode_q      <= ptss_pkg::MODE_WALL;
      mip_q       <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      k_q         <= '0;
      wlog_q      <= ptss_pkg::LOG2_W'(6);
      hlog_q      <= ptss_pkg::LOG2_W'(6);
      swim_vld_q  <= '0;
      vld_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      vld_rd_q <= swim_vld_q[sw_idx];
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          ptss_pkg::REG_TEX_WIDTH:  wlog_q <= cfg_data_i;
          ptss_pkg::REG_TEX_HEIGHT: hlog_q <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (command_i)
              ptss_pkg::CMD_LOAD: begin
                active_q <= 1'b0;
                if (pixel_count_i != '0 && draw_mode_i != ptss_pkg::MODE_NONE) begin
                  cnt_q     <= cnt_sat;
                  segs_q    <= cnt_sat[ptss_pkg::CNT_W-1:ptss_pkg::SEG_LOG2];
                  tail_q    <= cnt_sat[ptss_pkg::SEG_LOG2-1:0];
                  pos_q     <= '0;
                  mode_q    <= ptss_pkg::mode_e'(draw_mode_i);
                  mip_q     <= mip_level_i;
                  acc_z_q   <= $signed({2'b00, left_inv_depth_i});
                  acc_u_q   <= $signed({left_u_over_z_i[CW-1], left_u_over_z_i});
                  acc_v_q   <= $signed({left_v_over_z_i[CW-1], left_v_over_z_i});
                  end_z_q   <= right_inv_depth_i;
                  end_u_q   <= right_u_over_z_i;
                  end_v_q   <= right_v_over_z_i;
                  loading_q <= 1'b1;
                  op_q      <= OP_INC_Z;
                  state_q   <= ST_DIV_GO;
                end
              end
              ptss_pkg::CMD_STEP: begin
                if (active_q) begin
                  loading_q <= 1'b0;
                  full_q    <= (segs_q != '0);
                  op_q      <= OP_CRD_U;
                  state_q   <= ST_DIV_GO;
                end
              end
              ptss_pkg::CMD_SWIM: swim_vld_q[swim_index_i] <= 1'b1;
              default: ;
            endcase
          end
        end

        ST_DIV_GO: state_q <= ST_DIV_WAIT;

        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            state_q <= ST_DIV_GO;
            unique case (op_q)
              OP_INC_Z: begin
                inc_z_q <= div_rsp.quotient[AW-1:0];
                op_q    <= OP_INC_U;
              end
              OP_INC_U: begin
                inc_u_q <= div_rsp.quotient[AW-1:0];
                op_q    <= OP_INC_V;
              end
              OP_INC_V: begin
                inc_v_q <= div_rsp.quotient[AW-1:0];
                op_q    <= OP_CRD_U;
              end
              OP_CRD_U: begin
                nu_q <= ptss_pkg::sat32(div_rsp.quotient);
                op_q <= OP_CRD_V;
              end
              OP_CRD_V: begin
                nv_q    <= ptss_pkg::sat32(div_rsp.quotient);
                state_q <= (mode_q == ptss_pkg::MODE_SWIRL) ? ST_SW_RDV : ST_POST;
              end
              OP_TAIL_U: begin
                du_q <= div_rsp.quotient[CW-1:0];
                op_q <= OP_TAIL_V;
              end
              OP_TAIL_V: begin
                dv_q    <= div_rsp.quotient[CW-1:0];
                k_q     <= '0;
                state_q <= ST_EMIT;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end

        // swirl: u from the entry picked by v, then v from the entry picked by new u
        ST_SW_RDV: state_q <= ST_SW_ADDU;
        ST_SW_ADDU: begin
          nu_q    <= nu_q + sw_off;
          state_q <= ST_SW_RDU;
        end
        ST_SW_RDU: state_q <= ST_SW_ADDV;
        ST_SW_ADDV: begin
          nv_q    <= nv_q + sw_off;
          state_q <= ST_POST;
        end

        ST_POST: begin
          if (loading_q) begin
            acc_z_q  <= acc_z_q + inc_z_q;
            acc_u_q  <= acc_u_q + inc_u_q;
            acc_v_q  <= acc_v_q + inc_v_q;
            cur_u_q  <= nu_q;
            cur_v_q  <= nv_q;
            active_q <= 1'b1;
            state_q  <= ST_IDLE;
          end else if (full_q) begin
            du_q    <= step_u_sh[CW-1:0];
            dv_q    <= step_v_sh[CW-1:0];
            acc_z_q <= acc_z_q + inc_z_q;
            acc_u_q <= acc_u_q + inc_u_q;
            acc_v_q <= acc_v_q + inc_v_q;
            segs_q  <= segs_q - 1'b1;
            n_q     <= NW'(ptss_pkg::SEG_PIXELS);
            final_q <= (segs_q == ptss_pkg::SEGS_W'(1)) && (tail_q == '0);
            k_q     <= '0;
            state_q <= ST_EMIT;
          end else begin
            // tail: a single pixel needs no slope
            n_q     <= {1'b0, tail_q};
            tail_q  <= '0;
            final_q <= 1'b1;
            k_q     <= '0;
            if (tail_q > ptss_pkg::SEG_LOG2'(1)) begin
              op_q    <= OP_TAIL_U;
              state_q <= ST_DIV_GO;
            end else begin
              du_q    <= '0;
              dv_q    <= '0;
              state_q <= ST_EMIT;
            end
          end
        end

        ST_EMIT: begin
          if (fire) begin
            out_valid_q <= 1'b1;
            addr_q      <= pix_addr;
            oor_q       <= pix_oor;
            pix_q       <= pos_q;
            seg_last_q  <= last_pix;
            span_last_q <= last_pix && final_q;
            pos_q       <= pos_q + 1'b1;
            k_q         <= k_q + 1'b1;
            if (last_pix) begin
              cur_u_q <= nu_q;
              cur_v_q <= nv_q;
              if (final_q) begin
                active_q <= 1'b0;
              end
              state_q <= ST_IDLE;
            end else begin
              cur_u_q <= cur_u_q + du_q;
              cur_v_q <= cur_v_q + dv_q;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign texel_address_o = addr_q;
  assign pixel_index_o   = pix_q;
  assign out_of_range_o  = oor_q;
  assign segment_last_o  = seg_last_q;
  assign span_last_o     = span_last_q;

endmodule

### hw/rtl/ptss_checker.sv
module ptss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [19:0] texel_address_o,
  input logic [9:0]  pixel_index_o,
  input logic        segment_last_o,
  input logic        span_last_o
);

  // a span ends only on a segment end
  a_span_last_seg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && span_last_o |-> segment_last_o)
    else $error("span_last without segment_last");

  // mid-segment pixels come back to back with consecutive indices
  a_pix_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !segment_last_o
    |=> out_valid_o && (pixel_index_o == $past(pixel_index_o) + 10'd1))
    else $error("pixel sequence broken inside a segment");

  // block stays busy while a segment is still being emitted
  a_busy_mid_seg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !segment_last_o |-> in_stall_o)
    else $error("input accepted mid-segment");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(texel_address_o))
    else $error("stalled item changed");

endmodule

bind perspective_texture_span_stepper ptss_checker u_ptss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .texel_address_o (texel_address_o),
  .pixel_index_o   (pixel_index_o),
  .segment_last_o  (segment_last_o),
  .span_last_o     (span_last_o)
);
